/* rtl/smc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants of the sorted multiset engine
// Operation and status codes, request and result payloads, sequencer states
// and the command that the sequencer sends to every cell of the chain.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int VALUE_FIELD_W   = 32;
  localparam int MATCH_W         = 7;
  localparam int REMOVED_W       = 6;
  localparam int SIZE_W          = 7;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_COUNT    = 2'd2,
    OP_MAKE_SET = 2'd3
  } smc_op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } smc_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_DEDUP
  } smc_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_DEDUP
  } cell_op_t;

  typedef struct packed {
    smc_op_t                    operation;
    logic signed [VALUE_FIELD_W-1:0] value;
  } smc_in_t;

  typedef struct packed {
    smc_status_t          status;
    logic [MATCH_W-1:0]   match_count;
    logic [REMOVED_W-1:0] removed_count;
    logic [SIZE_W-1:0]    size;
    logic                 empty_res;
  } smc_out_t;

endpackage

/* rtl/smc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_cell: one slot of the sorted chain
// Holds one element and its valid bit, keeps the compare flags against the
// request value and takes its neighbor's element when the chain shifts.
// ----------------------------------------------------------------------------
module smc_cell #(
  parameter int VALUE_WIDTH = smc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  smc_pkg::cell_op_t      op,
  input  logic [VALUE_WIDTH-1:0] key_value,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic                   left_valid,
  input  logic                   left_gt,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic                   right_valid,
  input  logic                   shift_left,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   valid,
  output logic                   gt,
  output logic                   ge,
  output logic                   dup
);
  import smc_pkg::*;

  logic take_left;
  logic take_key;
  logic take_right;

  // Empty slots count as greater than any value, so both flags form a
  // thermometer code over the chain.
  always_comb begin
    take_left  = 1'b0;
    take_key   = 1'b0;
    take_right = 1'b0;
    unique case (op)
      CELL_INSERT: begin
        take_left = gt && left_gt;
        take_key  = gt && !left_gt;
      end
      CELL_REMOVE: take_right = ge;
      CELL_DEDUP:  take_right = shift_left;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      gt    <= 1'b0;
      ge    <= 1'b0;
    end else begin
      if (op == CELL_EVAL) begin
        gt <= !valid || ($signed(value) > $signed(key_value));
        ge <= !valid || ($signed(value) >= $signed(key_value));
      end
      if (take_left) begin
        valid <= left_valid;
      end else if (take_key) begin
        valid <= 1'b1;
      end else if (take_right) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_left) begin
      value <= left_value;
    end else if (take_key) begin
      value <= key_value;
    end else if (take_right) begin
      value <= right_value;
    end
  end

  assign dup = valid && left_valid && (value == left_value);

endmodule

/* rtl/sorted_multiset_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_multiset_engine: bounded multiset kept in ascending order
// A chain of cells holds the elements packed from slot 0; a small sequencer
// drives insert, remove, count and make-set requests through the chain.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   request   start, busy        cmd    (operation, value)
//   result    done (strobe)      result (status, match_count, removed_count,
//                                        size, empty_res)
//
// Insert, remove and count: the cells compare in the cycle the request is
// taken and shift in the next; the result follows in the cycle after that,
// while a new request may already be taken. Make-set removes one duplicate
// per cycle through the chain and gives its result once none is left.
// After reset the store is empty and a request may be taken at once.
// The result strobe cannot be held off by the receiver.
//
module sorted_multiset_engine #(
  parameter int CAPACITY    = smc_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = smc_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  smc_pkg::smc_in_t cmd,
  output logic             busy,
  output logic             done,
  output smc_pkg::smc_out_t result
);
  import smc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  smc_state_t state;
  smc_state_t state_next;

  smc_op_t                op_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [CW-1:0]          size_q;
  logic [CW-1:0]          size_next;
  logic [CW-1:0]          removed_q;
  logic [CW-1:0]          removed_next;
  smc_out_t               result_next;
  logic                   done_next;

  logic                   accept;
  logic [63:0]            in_wide;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [VALUE_WIDTH-1:0] cell_key;
  cell_op_t               cell_op;

  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]    valid_vec;
  logic [CAPACITY-1:0]    gt_vec;
  logic [CAPACITY-1:0]    ge_vec;
  logic [CAPACITY-1:0]    dup_vec;
  logic [CAPACITY-1:0]    shift_vec;

  logic [CAPACITY:0]      ge_ext;
  logic [CAPACITY:0]      gt_ext;
  logic [CAPACITY:0]      first_ge;
  logic [CAPACITY:0]      first_gt;
  logic [CW-1:0]          idx_ge;
  logic [CW-1:0]          idx_gt;
  logic                   full;
  logic                   found;
  logic                   any_dup;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  // The request value is signed, so it is sign-extended to the element width.
  assign in_wide  = {{(64 - VALUE_FIELD_W){cmd.value[VALUE_FIELD_W-1]}}, cmd.value};
  assign in_value = in_wide[VALUE_WIDTH-1:0];
  assign cell_key = (state == S_IDLE) ? in_value : key_q;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lv;
    logic [VALUE_WIDTH-1:0] rv;
    logic                   lval;
    logic                   lgt;
    logic                   rval;

    if (g == 0) begin : g_first
      assign lv   = '0;
      assign lval = 1'b0;
      assign lgt  = 1'b0;
    end else begin : g_inner_l
      assign lv   = cell_value[g-1];
      assign lval = valid_vec[g-1];
      assign lgt  = gt_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_inner_r
      assign rv   = cell_value[g+1];
      assign rval = valid_vec[g+1];
    end

    smc_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cell_op),
      .key_value   (cell_key),
      .left_value  (lv),
      .left_valid  (lval),
      .left_gt     (lgt),
      .right_value (rv),
      .right_valid (rval),
      .shift_left  (shift_vec[g]),
      .value       (cell_value[g]),
      .valid       (valid_vec[g]),
      .gt          (gt_vec[g]),
      .ge          (ge_vec[g]),
      .dup         (dup_vec[g])
    );
  end

  // --------------------------------------------------------------------------
  // Boundary encoders: copies of the value sit between the first slot that
  // is not below it and the first slot that is above it.
  // --------------------------------------------------------------------------
  assign ge_ext   = {1'b1, ge_vec};
  assign gt_ext   = {1'b1, gt_vec};
  assign first_ge = ge_ext & ~{ge_ext[CAPACITY-1:0], 1'b0};
  assign first_gt = gt_ext & ~{gt_ext[CAPACITY-1:0], 1'b0};

  always_comb begin
    idx_ge = '0;
    idx_gt = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (first_ge[i]) idx_ge = idx_ge | CW'(i);
      if (first_gt[i]) idx_gt = idx_gt | CW'(i);
    end
  end

  assign full  = (size_q == CW'(CAPACITY));
  assign found = (idx_gt != idx_ge);

  // Every slot from the first duplicate onward moves one place down.
  always_comb begin
    shift_vec = dup_vec;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      shift_vec = shift_vec | (shift_vec << s);
    end
  end

  assign any_dup = |dup_vec;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd.operation == OP_MAKE_SET) ? S_DEDUP : S_APPLY;
        end
      end
      S_APPLY: state_next = S_IDLE;
      S_DEDUP: begin
        if (!any_dup) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cell_op      = CELL_HOLD;
    size_next    = size_q;
    removed_next = removed_q;
    done_next    = 1'b0;
    result_next  = result;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cell_op      = CELL_EVAL;
          removed_next = '0;
        end
      end
      S_APPLY: begin
        done_next                 = 1'b1;
        result_next.status        = ST_DONE;
        result_next.match_count   = '0;
        result_next.removed_count = '0;
        unique case (op_q)
          OP_INSERT: begin
            if (full) begin
              result_next.status = ST_FULL;
            end else begin
              cell_op   = CELL_INSERT;
              size_next = size_q + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (found) begin
              cell_op   = CELL_REMOVE;
              size_next = size_q - 1'b1;
            end else begin
              result_next.status = ST_NOT_FOUND;
            end
          end
          OP_COUNT: result_next.match_count = MATCH_W'(idx_gt - idx_ge);
          default: ;
        endcase
        result_next.size      = SIZE_W'(size_next);
        result_next.empty_res = (size_next == '0);
      end
      S_DEDUP: begin
        if (any_dup) begin
          cell_op      = CELL_DEDUP;
          size_next    = size_q - 1'b1;
          removed_next = removed_q + 1'b1;
        end else begin
          done_next                 = 1'b1;
          result_next.status        = ST_DONE;
          result_next.match_count   = '0;
          result_next.removed_count = REMOVED_W'(removed_q);
          result_next.size          = SIZE_W'(size_q);
          result_next.empty_res     = (size_q == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size_q    <= '0;
      removed_q <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      size_q    <= size_next;
      removed_q <= removed_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      op_q  <= cmd.operation;
      key_q <= in_value;
    end
  end

`ifndef SYNTHESIS
  // A single-pass request always produces its result, through the apply state and the done register.
  a_single_pass_done: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.operation != OP_MAKE_SET) |=> ##1 done)
    else $error("single-pass request without result");

  // Occupied slots stay packed from slot 0.
  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied slots not packed");

  // The size register tracks the occupied slots.
  a_size_tracks: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(size_q))
    else $error("size does not match occupied slots");

  // A result is only shown once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while a request is in progress");
`endif

endmodule

/* tb/smc_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_result_checker: scoreboard for the sorted multiset engine
// Watches the request and result channels. Every request transfer is run
// through a local copy of the multiset to predict its result. Every result
// strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module smc_result_checker
  import smc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  smc_in_t  cmd,
  input  logic     done,
  input  smc_out_t result,
  output int       failures,
  output int       pending,
  output int       checked,
  output int       full_seen,
  output int       absent_seen,
  output int       dups_removed
);

  localparam int CAPACITY = CAPACITY_DEF;

  // Local copy of the store, kept in ascending order.
  logic signed [VALUE_FIELD_W-1:0] held [$];
  smc_out_t                        expected_q [$];

  int fail_count   = 0;
  int check_count  = 0;
  int full_count   = 0;
  int absent_count = 0;
  int dedup_count  = 0;

  assign failures     = fail_count;
  assign pending      = expected_q.size();
  assign checked      = check_count;
  assign full_seen    = full_count;
  assign absent_seen  = absent_count;
  assign dups_removed = dedup_count;

  function automatic smc_out_t apply_request(smc_in_t req);
    smc_out_t                        res;
    logic signed [VALUE_FIELD_W-1:0] v;
    logic signed [VALUE_FIELD_W-1:0] distinct_q [$];
    int                              pos;
    int                              hits;
    res        = '0;
    res.status = ST_DONE;
    v          = req.value;
    case (req.operation)
      OP_INSERT: begin
        if (held.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // New copies go after any equal values.
          pos = 0;
          while (pos < held.size() && held[pos] <= v) pos++;
          held.insert(pos, v);
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < held.size() && held[pos] != v) pos++;
        if (pos >= held.size()) res.status = ST_NOT_FOUND;
        else held.delete(pos);
      end
      OP_COUNT: begin
        hits = 0;
        foreach (held[i]) if (held[i] == v) hits++;
        res.match_count = MATCH_W'(hits);
      end
      OP_MAKE_SET: begin
        foreach (held[i]) begin
          if (distinct_q.size() == 0 || distinct_q[distinct_q.size() - 1] != held[i])
            distinct_q.push_back(held[i]);
        end
        res.removed_count = REMOVED_W'(held.size() - distinct_q.size());
        held = distinct_q;
      end
    endcase
    res.size      = SIZE_W'(held.size());
    res.empty_res = (held.size() == 0);
    return res;
  endfunction

  task automatic check_fields(smc_out_t got, smc_out_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.match_count !== want.match_count) begin
      $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
      fail_count++;
    end
    if (got.removed_count !== want.removed_count) begin
      $error("removed_count: expected %0d, got %0d", want.removed_count, got.removed_count);
      fail_count++;
    end
    if (got.size !== want.size) begin
      $error("size: expected %0d, got %0d", want.size, got.size);
      fail_count++;
    end
    if (got.empty_res !== want.empty_res) begin
      $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    smc_out_t want;
    if (!rst) begin
      // A result always belongs to an earlier request, so compare before
      // queuing the prediction for a request taken on this same edge.
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_fields(result, want);
          check_count++;
          if (want.status == ST_FULL) full_count++;
          if (want.status == ST_NOT_FOUND) absent_count++;
          dedup_count += want.removed_count;
        end
      end
      if (start && !busy) expected_q.push_back(apply_request(cmd));
    end
  end

endmodule

/* tb/tb_sorted_multiset_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_multiset_engine: stimulus and verdict for the multiset engine
// A directed opening covers the empty store, the value extremes, duplicates
// and every operation; random bursts then grow, shrink and fill the store
// from small value palettes under four request pacing phases.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_engine;
  import smc_pkg::*;

  typedef enum int {
    BURST_GROW,
    BURST_SHRINK,
    BURST_BALANCED,
    BURST_FILL
  } burst_kind_t;

  localparam int PHASE_ITEMS = 425;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  smc_in_t  cmd = '0;
  logic     busy;
  logic     done;
  smc_out_t result;

  int failures, pending, checked, full_seen, absent_seen, dups_removed;

  int idle_pct = 0;
  int ops_sent [4];
  int items_sent = 0;

  logic signed [VALUE_FIELD_W-1:0] palette [8];
  int                              palette_n = 1;

  sorted_multiset_engine u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  smc_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .result       (result),
    .failures     (failures),
    .pending      (pending),
    .checked      (checked),
    .full_seen    (full_seen),
    .absent_seen  (absent_seen),
    .dups_removed (dups_removed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [VALUE_FIELD_W-1:0] extreme_value();
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0000_0000;
      default: return 32'shFFFF_FFFF;
    endcase
  endfunction

  // Small palettes make duplicates, hits on remove and count, and long
  // make-set passes common.
  task automatic refresh_palette();
    int r;
    palette_n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(3);
      if (r < 2) palette[i] = $signed($urandom_range(20)) - 10;
      else if (r == 2) palette[i] = $urandom;
      else palette[i] = extreme_value();
    end
  endtask

  function automatic logic signed [VALUE_FIELD_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 80) return palette[$urandom_range(palette_n - 1)];
    else if (r < 95) return $urandom;
    else return extreme_value();
  endfunction

  task automatic send_request(smc_op_t op, logic signed [VALUE_FIELD_W-1:0] val);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= '{operation: op, value: val};
    @(posedge clk);
    while (busy) @(posedge clk);
    ops_sent[op]++;
    items_sent++;
  endtask

  // Holds requests off until every outstanding result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic smc_op_t pick_op(burst_kind_t kind);
    int r;
    int w_ins, w_rem, w_cnt;
    r = $urandom_range(99);
    case (kind)
      BURST_GROW:   begin w_ins = 60; w_rem = 15; w_cnt = 17; end
      BURST_SHRINK: begin w_ins = 15; w_rem = 60; w_cnt = 17; end
      default:      begin w_ins = 35; w_rem = 30; w_cnt = 25; end
    endcase
    if (r < w_ins) return OP_INSERT;
    else if (r < w_ins + w_rem) return OP_REMOVE;
    else if (r < w_ins + w_rem + w_cnt) return OP_COUNT;
    else return OP_MAKE_SET;
  endfunction

  task automatic run_burst(output int sent);
    burst_kind_t kind;
    int          len;
    smc_op_t     op;
    refresh_palette();
    case ($urandom_range(9))
      0, 1, 2: kind = BURST_GROW;
      3, 4:    kind = BURST_SHRINK;
      5:       kind = BURST_FILL;
      default: kind = BURST_BALANCED;
    endcase
    sent = 0;
    if (kind == BURST_FILL) begin
      // Enough inserts to reach capacity from any size, then some rejected.
      repeat (CAPACITY_DEF + 6) begin
        send_request(OP_INSERT, pick_value());
        sent++;
      end
      send_request(OP_MAKE_SET, $urandom);
      sent++;
    end else begin
      len = $urandom_range(10, 40);
      repeat (len) begin
        op = pick_op(kind);
        send_request(op, (op == OP_MAKE_SET) ? $signed($urandom) : pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    int sent;
    int phase_items;

    foreach (ops_sent[i]) ops_sent[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: empty store, extremes, duplicates, absent values.
    send_request(OP_COUNT,    32'sh0000_0000);
    send_request(OP_REMOVE,   32'sh0000_0005);
    send_request(OP_MAKE_SET, 32'sh1234_5678);
    send_request(OP_INSERT,   32'sh7FFF_FFFF);
    send_request(OP_INSERT,   32'sh8000_0000);
    send_request(OP_INSERT,   32'sh0000_0000);
    send_request(OP_INSERT,   32'shFFFF_FFFF);
    send_request(OP_INSERT,   32'sh0000_0000);
    send_request(OP_INSERT,   32'sh0000_0000);
    send_request(OP_COUNT,    32'sh0000_0000);
    send_request(OP_COUNT,    32'sh8000_0000);
    send_request(OP_REMOVE,   32'sh0000_3039);
    send_request(OP_MAKE_SET, 32'shFFFF_FFFF);
    send_request(OP_MAKE_SET, 32'sh0000_0000);
    send_request(OP_COUNT,    32'sh0000_0000);
    send_request(OP_REMOVE,   32'sh7FFF_FFFF);
    send_request(OP_REMOVE,   32'sh8000_0000);
    send_request(OP_REMOVE,   32'shFFFF_FFFF);
    send_request(OP_REMOVE,   32'sh0000_0000);
    send_request(OP_COUNT,    32'sh7FFF_FFFF);
    send_request(OP_MAKE_SET, 32'sh7FFF_FFFF);
    wait_results_drained();

    // Pacing phases: back to back, sparse requests, back to back, light gaps.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 65;
        3:       idle_pct = 13;
        default: idle_pct = 0;
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        run_burst(sent);
        phase_items += sent;
      end
      wait_results_drained();
    end

    // Catch any stray result strobe after the last expected one.
    repeat (100) @(posedge clk);

    $display("Sent %0d requests: %0d insert, %0d remove, %0d count, %0d make-set.",
             items_sent, ops_sent[OP_INSERT], ops_sent[OP_REMOVE],
             ops_sent[OP_COUNT], ops_sent[OP_MAKE_SET]);
    $display("Checked %0d results: %0d full rejects, %0d absent removes, %0d copies deduped.",
             checked, full_seen, absent_seen, dups_removed);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
